[design/footswitch_delayed_output_timer_defines.svh]
// Assertion macros shared by the footswitch delayed output timer.
// Depends on nothing; files that check their logic take it by include.
`ifndef FOOTSWITCH_DELAYED_OUTPUT_TIMER_DEFINES_SVH
`define FOOTSWITCH_DELAYED_OUTPUT_TIMER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define FDT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define FDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/fdt_pkg.sv]
// Shared widths, constants and register map of the footswitch delayed output timer.
// Depends on nothing.
package fdt_pkg;

  // Field widths
  localparam int unsigned KnobW     = 12;
  localparam int unsigned LevelW    = 12;
  localparam int unsigned CfgW      = 10;
  localparam int unsigned DelayW    = 14;
  localparam int unsigned BeepW     = 10;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;

  // Register map: index taken from paddr bit 2
  localparam logic RegBeepTicks = 1'b0;
  localparam logic RegMinDelay  = 1'b1;

  localparam logic [CfgW-1:0] BeepTicksRst = CfgW'(300);
  localparam logic [CfgW-1:0] MinDelayRst  = CfgW'(10);

  localparam logic [LevelW-1:0] LevelMax = LevelW'(4095);

  // Delay scale knob * 1000 / 273, done as one multiply by a rounded-up
  // reciprocal. With a 21-bit shift the error stays below 1/273 over the
  // whole knob range, so the floor is exact with no correction step.
  localparam longint unsigned DelayNum   = 1000;
  localparam longint unsigned DelayDen   = 273;
  localparam int unsigned     RecipShift = 21;
  localparam longint unsigned RecipMulL  =
    ((64'd1 << RecipShift) * DelayNum + DelayDen - 1) / DelayDen;
  localparam int unsigned     RecipW     = 23;
  localparam logic [RecipW-1:0] RecipMul = RecipMulL[RecipW-1:0];
  localparam int unsigned     ProdW      = KnobW + RecipW;

endpackage

[design/fdt_in_if.sv]
// Input channel of the footswitch delayed output timer: one tick beat.
// Depends on fdt_pkg for field widths.
interface fdt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        pedal_pressed;
  logic [fdt_pkg::KnobW-1:0]   delay_knob;
  logic [fdt_pkg::KnobW-1:0]   level_knob;

  modport source (output valid, output pedal_pressed, output delay_knob,
                  output level_knob, input ready);
  modport sink   (input valid, input pedal_pressed, input delay_knob,
                  input level_knob, output ready);
endinterface

[design/fdt_out_if.sv]
// Result channel of the footswitch delayed output timer: one result beat per tick.
// Depends on fdt_pkg for field widths.
interface fdt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        buzzer_on;
  logic [fdt_pkg::LevelW-1:0]  output_level;
  logic                        level_write;
  logic                        delay_pending;

  modport source (output valid, output buzzer_on, output output_level,
                  output level_write, output delay_pending, input ready);
  modport sink   (input valid, input buzzer_on, input output_level,
                  input level_write, input delay_pending, output ready);
endinterface

[design/footswitch_delayed_output_timer.sv]
// Footswitch delayed output timer: top level with tick logic and APB registers.
// Depends on fdt_pkg, fdt_in_if, fdt_out_if and the assertion macro header.
//
// Usage:
//   in_chan carries one beat per 1 ms tick: pedal level and two knob readings.
//   out_chan returns exactly one result beat per input beat, in order:
//   buzzer drive, held output level, a level-write strobe and the pending flag.
//   A beat is taken into an input register, then the next state and result
//   are formed in one pass of logic (one 12x23 multiply for the delay scale
//   plus counters and compares) and land in the result register.
//   Throughput is one beat per cycle while out_chan.ready stays high, set
//   by the single-pass tick logic. When the receiver stalls, the result
//   holds and the input register keeps one more beat; input ready drops
//   only while both are full. Reset clears the pedal history, countdown,
//   beep, buzzer and level; loads beep_ticks = 300 and min_delay_ticks = 10.
//   The user must write the two registers over the APB port (paddr 0 and 4)
//   only while the block is idle, which it does not enforce; pready stays high.
`include "footswitch_delayed_output_timer_defines.svh"

module footswitch_delayed_output_timer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fdt_in_if.sink                         in_chan,
  fdt_out_if.source                      out_chan,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [fdt_pkg::ApbAddrW-1:0]   paddr_i,
  input  logic [fdt_pkg::ApbDataW-1:0]   pwdata_i,
  output logic [fdt_pkg::ApbDataW-1:0]   prdata_o,
  output logic                           pready_o
);

  // Configuration registers
  logic [fdt_pkg::CfgW-1:0] beep_ticks_q, min_delay_q;
  logic                     cfg_wr;

  // Input register
  logic                       in_valid_q;
  logic                       pedal_q;
  logic [fdt_pkg::KnobW-1:0]  dknob_q, lknob_q;

  // Tick state, also the result payload
  logic                        pedal_prev_q, pedal_prev_d;
  logic                        pending_q, pending_d;
  logic [fdt_pkg::DelayW-1:0]  delay_left_q, delay_left_d;
  logic [fdt_pkg::BeepW-1:0]   beep_left_q, beep_left_d;
  logic                        buzzer_q, buzzer_d;
  logic [fdt_pkg::LevelW-1:0]  level_q, level_d;
  logic                        wrote_q, wrote_d;
  logic                        out_valid_q;

  logic                        advance;
  logic                        in_accept;
  logic [fdt_pkg::ProdW-1:0]   prod;
  logic [fdt_pkg::DelayW-1:0]  scaled, load_delay;

  // APB: no wait states, register picked by paddr bit 2
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    unique case (paddr_i[2])
      fdt_pkg::RegBeepTicks: prdata_o = fdt_pkg::ApbDataW'(beep_ticks_q);
      fdt_pkg::RegMinDelay:  prdata_o = fdt_pkg::ApbDataW'(min_delay_q);
      default:               prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beep_ticks_q <= fdt_pkg::BeepTicksRst;
      min_delay_q  <= fdt_pkg::MinDelayRst;
    end else if (cfg_wr) begin
      if (paddr_i[2] == fdt_pkg::RegBeepTicks) begin
        beep_ticks_q <= pwdata_i[fdt_pkg::CfgW-1:0];
      end else begin
        min_delay_q <= pwdata_i[fdt_pkg::CfgW-1:0];
      end
    end
  end

  // Handshake: move a beat on when the result register is free or drains
  assign advance        = in_valid_q && (!out_valid_q || out_chan.ready);
  assign in_chan.ready  = !in_valid_q || advance;
  assign in_accept      = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pedal_q <= in_chan.pedal_pressed;
      dknob_q <= in_chan.delay_knob;
      lknob_q <= in_chan.level_knob;
    end
  end

  // Scale the delay knob: floor(knob * 1000 / 273), clamp below to min and 1
  assign prod   = fdt_pkg::ProdW'(dknob_q) * fdt_pkg::ProdW'(fdt_pkg::RecipMul);
  assign scaled = prod[fdt_pkg::RecipShift +: fdt_pkg::DelayW];

  always_comb begin
    load_delay = scaled;
    if (scaled < fdt_pkg::DelayW'(min_delay_q)) begin
      load_delay = fdt_pkg::DelayW'(min_delay_q);
    end
    if (load_delay == '0) begin
      load_delay = fdt_pkg::DelayW'(1);
    end
  end

  // Tick logic: beep countdown, delay countdown, then pedal edges
  always_comb begin
    beep_left_d  = beep_left_q;
    buzzer_d     = buzzer_q;
    pending_d    = pending_q;
    delay_left_d = delay_left_q;
    level_d      = level_q;
    wrote_d      = 1'b0;
    pedal_prev_d = pedal_q;

    if (beep_left_d != '0) begin
      beep_left_d = beep_left_d - fdt_pkg::BeepW'(1);
      if (beep_left_d == '0) begin
        buzzer_d = 1'b0;
      end
    end

    if (pending_q) begin
      if (delay_left_d != '0) begin
        delay_left_d = delay_left_d - fdt_pkg::DelayW'(1);
      end
      if (delay_left_d == '0) begin
        pending_d = 1'b0;
        if (pedal_q) begin
          level_d     = (lknob_q > fdt_pkg::LevelMax) ? fdt_pkg::LevelMax : lknob_q;
          wrote_d     = 1'b1;
          beep_left_d = beep_ticks_q;
          buzzer_d    = (beep_ticks_q != '0);
        end
      end
    end

    // Press edge with nothing pending: load countdown and beep
    if (pedal_q && !pedal_prev_q && !pending_d) begin
      delay_left_d = load_delay;
      pending_d    = 1'b1;
      beep_left_d  = beep_ticks_q;
      buzzer_d     = (beep_ticks_q != '0);
    end

    // Release edge: cancel everything and drop the level
    if (!pedal_q && pedal_prev_q) begin
      pending_d    = 1'b0;
      delay_left_d = '0;
      beep_left_d  = '0;
      buzzer_d     = 1'b0;
      level_d      = '0;
      wrote_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pedal_prev_q <= 1'b0;
      pending_q    <= 1'b0;
      delay_left_q <= '0;
      beep_left_q  <= '0;
      buzzer_q     <= 1'b0;
      level_q      <= '0;
      wrote_q      <= 1'b0;
    end else if (advance) begin
      pedal_prev_q <= pedal_prev_d;
      pending_q    <= pending_d;
      delay_left_q <= delay_left_d;
      beep_left_q  <= beep_left_d;
      buzzer_q     <= buzzer_d;
      level_q      <= level_d;
      wrote_q      <= wrote_d;
    end
  end

  // Result beat comes straight from the state
  assign out_chan.valid         = out_valid_q;
  assign out_chan.buzzer_on     = buzzer_q;
  assign out_chan.output_level  = level_q;
  assign out_chan.level_write   = wrote_q;
  assign out_chan.delay_pending = pending_q;

  // A countdown only runs while the pedal is held
  `FDT_ASSERT(pend_needs_pedal_a, clk_i, rst_ni, pending_q |-> pedal_prev_q, "pending without pedal held")
  // A running countdown never sits at zero
  `FDT_ASSERT(pend_nonzero_a, clk_i, rst_ni, pending_q |-> (delay_left_q != '0), "pending with empty countdown")
  // The buzzer is on only while a beep counts
  `FDT_ASSERT(buzzer_beep_a, clk_i, rst_ni, buzzer_q |-> (beep_left_q != '0), "buzzer on with no beep left")
  // Applying a nonzero level ends the countdown
  `FDT_ASSERT(level_ends_pend_a, clk_i, rst_ni, (out_valid_q && wrote_q && (level_q != '0)) |-> !pending_q, "level applied while still pending")

endmodule
